// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared assertion forms for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define CHK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rhlsh_pkg.sv =====
// ----------------------------------------------------------------------------
// rhlsh_pkg
// shared types and constants of the random hyperplane lsh signature core
// ----------------------------------------------------------------------------
package rhlsh_pkg;

  localparam int NUM_PLANES_DEF   = 10;
  localparam int VECTOR_DIM_DEF   = 5;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAX_SW           = 32;

  localparam int FIELD_W   = 16;
  localparam int IN_ELEMS  = 5;
  localparam int IN_W      = 112;
  localparam int OUT_W     = 16;
  localparam int SIG_OUT_W = 10;
  localparam int DIST_W    = 4;
  localparam int DIST_MAX  = 15;

  // input item layout
  localparam int CMD_LSB   = 0;
  localparam int PLANE_LSB = 2;
  localparam int DIM_LSB   = 6;
  localparam int COEF_LSB  = 9;
  localparam int X_LSB     = 25;

  // output item layout
  localparam int SIG_LSB   = 0;
  localparam int DIST_LSB  = 10;

  typedef enum logic [1:0] {
    CMD_LOAD       = 2'd0,
    CMD_HASH       = 2'd1,
    CMD_HASH_STORE = 2'd2
  } cmd_t;

endpackage

// ===== rtl/random_hyperplane_lsh_signature_core.sv =====
// path: a hash item passes the vector, product, sign and result registers in turn
//   to m_tdata; loads take effect at the accepting edge and give no result
// throughput: one item per cycle unless m_tready stalls the four-stage pipe named above
// reset: clears all valid flags and the reference signature; the coefficient table
//   is not cleared and must be loaded before use
// ----------------------------------------------------------------------------
// random_hyperplane_lsh_signature_core
// simhash signature of a vector against a loaded table of hyperplanes, with
// hamming distance to a stored reference signature
// ----------------------------------------------------------------------------
module random_hyperplane_lsh_signature_core #(
  parameter int NUM_PLANES   = rhlsh_pkg::NUM_PLANES_DEF,
  parameter int VECTOR_DIM   = rhlsh_pkg::VECTOR_DIM_DEF,
  parameter int SAMPLE_WIDTH = rhlsh_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // cmd, plane_index, dim_index, coef_value, x0, x1, x2, x3, x4
  input  logic [rhlsh_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // signature, distance_to_reference
  output logic [rhlsh_pkg::OUT_W-1:0] m_tdata
);
  import rhlsh_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int PW    = 2 * SW;
  localparam int SUM_W = PW + $clog2(VECTOR_DIM) + 1;
  localparam int CNT_W = $clog2(NUM_PLANES + 1);

  function automatic logic signed [SW-1:0] to_sample(input logic [FIELD_W-1:0] f);
    logic [MAX_SW-1:0] ext;
    ext = MAX_SW'(f);
    return $signed(ext[SW-1:0]);
  endfunction

  // input fields
  logic [1:0]         cmd_in;
  logic [3:0]         plane_in;
  logic [2:0]         dim_in;
  logic [FIELD_W-1:0] coef_in;
  logic [FIELD_W-1:0] xin [IN_ELEMS];

  assign cmd_in   = s_tdata[CMD_LSB +: 2];
  assign plane_in = s_tdata[PLANE_LSB +: 4];
  assign dim_in   = s_tdata[DIM_LSB +: 3];
  assign coef_in  = s_tdata[COEF_LSB +: FIELD_W];

  for (genvar e = 0; e < IN_ELEMS; e++) begin : g_xin
    assign xin[e] = s_tdata[X_LSB + e*FIELD_W +: FIELD_W];
  end

  // pipeline flow
  logic v1, v2, v3;
  logic r1, r2, r3, r4;
  logic accept, load_en, hash_en, store_in;

  assign r4       = !m_tvalid || m_tready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign s_tready = r1;
  assign accept   = s_tvalid && r1;

  always_comb begin
    load_en  = 1'b0;
    hash_en  = 1'b0;
    store_in = 1'b0;
    unique case (cmd_in)
      CMD_LOAD:       load_en = accept;
      CMD_HASH:       hash_en = accept;
      CMD_HASH_STORE: begin
        hash_en  = accept;
        store_in = 1'b1;
      end
      default: ;
    endcase
  end

  // coefficient table, one register per plane and dimension
  logic signed [SW-1:0] coef [NUM_PLANES][VECTOR_DIM];
  logic signed [SW-1:0] coef_s;

  assign coef_s = to_sample(coef_in);

  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int d = 0; d < VECTOR_DIM; d++) begin
        if (load_en && int'(plane_in) == p && int'(dim_in) == d) begin
          coef[p][d] <= coef_s;
        end
      end
    end
  end

  // stage 1: vector register
  logic signed [SW-1:0] xs [VECTOR_DIM];
  logic signed [SW-1:0] xr [VECTOR_DIM];
  logic                 st1;

  for (genvar d = 0; d < VECTOR_DIM; d++) begin : g_xs
    if (d < IN_ELEMS) begin : g_in
      assign xs[d] = to_sample(xin[d]);
    end else begin : g_zero
      assign xs[d] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= hash_en;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      st1 <= store_in;
      xr  <= xs;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] prod [NUM_PLANES][VECTOR_DIM];
  logic                 st2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      st2 <= st1;
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int d = 0; d < VECTOR_DIM; d++) begin
          prod[p][d] <= PW'(xr[d]) * PW'(coef[p][d]);
        end
      end
    end
  end

  // stage 3: dot product signs
  logic [NUM_PLANES-1:0] sig_c;
  logic [NUM_PLANES-1:0] sig3;
  logic                  st3;

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc = '0;
      for (int d = 0; d < VECTOR_DIM; d++) begin
        acc = acc + SUM_W'(prod[p][d]);
      end
      sig_c[p] = !acc[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      st3  <= st2;
      sig3 <= sig_c;
    end
  end

  // stage 4: distance, reference and result register
  logic [NUM_PLANES-1:0] ref_sig;
  logic [NUM_PLANES-1:0] diff;
  logic [CNT_W-1:0]      cnt;
  logic [DIST_W-1:0]     dist_c;
  logic [SIG_OUT_W-1:0]  sig_out;
  logic [SIG_OUT_W-1:0]  sig_o;
  logic [DIST_W-1:0]     dist_o;

  assign diff = sig3 ^ ref_sig;

  always_comb begin
    cnt = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      cnt = cnt + CNT_W'(diff[p]);
    end
    if (int'(cnt) > DIST_MAX) begin
      dist_c = DIST_W'(DIST_MAX);
    end else begin
      dist_c = DIST_W'(cnt);
    end
  end

  for (genvar i = 0; i < SIG_OUT_W; i++) begin : g_sig
    if (i < NUM_PLANES) begin : g_plane
      assign sig_out[i] = sig3[i];
    end else begin : g_none
      assign sig_out[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_sig  <= '0;
      m_tvalid <= 1'b0;
    end else if (r4) begin
      m_tvalid <= v3;
      if (v3 && st3) begin
        ref_sig <= sig3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      sig_o  <= sig_out;
      dist_o <= dist_c;
    end
  end

  assign m_tdata = OUT_W'({dist_o, sig_o});

endmodule

// ===== rtl/rhlsh_chk.sv =====
// ----------------------------------------------------------------------------
// rhlsh_chk
// port-level checks on the random hyperplane lsh signature core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhlsh_chk #(
  parameter int NUM_PLANES = rhlsh_pkg::NUM_PLANES_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [rhlsh_pkg::OUT_W-1:0] m_tdata
);
  import rhlsh_pkg::*;

  localparam int DIST_BOUND = (NUM_PLANES < DIST_MAX) ? NUM_PLANES : DIST_MAX;

  logic [SIG_OUT_W-1:0] sig_f;
  logic [DIST_W-1:0]    dist_f;
  logic [SIG_OUT_W-1:0] used_mask;

  assign sig_f  = m_tdata[SIG_LSB +: SIG_OUT_W];
  assign dist_f = m_tdata[DIST_LSB +: DIST_W];

  for (genvar i = 0; i < SIG_OUT_W; i++) begin : g_mask
    assign used_mask[i] = (i < NUM_PLANES);
  end

  // nothing leaves the core straight out of reset
  `CHK_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

  // a stalled result holds
  `CHK_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
              "stalled result changed")

  // an empty output never blocks the input
  `CHK_ASSERT(a_ready_empty, !m_tvalid |-> s_tready, "input blocked with empty output")

  // distance bounded by the plane count
  `CHK_ASSERT(a_dist_bound, m_tvalid |-> int'(dist_f) <= DIST_BOUND,
              "distance above plane count")

  // signature bits past the last plane stay clear
  `CHK_ASSERT(a_sig_unused, m_tvalid |-> (sig_f & ~used_mask) == '0,
              "signature bit beyond planes")

endmodule

bind random_hyperplane_lsh_signature_core rhlsh_chk #(
  .NUM_PLANES(NUM_PLANES)
) u_rhlsh_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for random_hyperplane_lsh_signature_core: loads the
// hyperplane table, hashes directed and random vectors against a local simhash
// predictor and checks signature and reference distance under random stalls
// ----------------------------------------------------------------------------
module tb_top;
  import rhlsh_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         N_COEF     = NUM_PLANES_DEF * VECTOR_DIM_DEF;
  localparam int         IDLE_LIMIT = 1000;
  localparam int         DRAIN_WAIT = 12;

  typedef struct packed {
    logic [SIG_OUT_W-1:0] signature;
    logic [DIST_W-1:0]    distance;
  } lsh_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  logic signed [FIELD_W-1:0] plane_coef [N_COEF];
  logic [SIG_OUT_W-1:0]      ref_signature;
  lsh_result_t               expected_signatures [$];
  lsh_result_t               got, want;
  int unsigned               send_idle_pct = 0;
  int unsigned               recv_stall_pct = 0;
  int                        error_count = 0;
  int                        idle_cycles = 0;

  random_hyperplane_lsh_signature_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // fields from bit 0: cmd, plane_index, dim_index, coef_value, x0..x4, zero fill
  function automatic logic [IN_W-1:0] pack_item(input logic [1:0] cmd,
      input logic [3:0] plane, input logic [2:0] dim, input logic [15:0] coef,
      input logic [15:0] x0, input logic [15:0] x1, input logic [15:0] x2,
      input logic [15:0] x3, input logic [15:0] x4);
    logic [IN_W-1:0] item;
    item = '0;
    item[CMD_LSB +: 2]          = cmd;
    item[PLANE_LSB +: 4]        = plane;
    item[DIM_LSB +: 3]          = dim;
    item[COEF_LSB +: FIELD_W]   = coef;
    item[X_LSB +: FIELD_W]      = x0;
    item[X_LSB + 16 +: FIELD_W] = x1;
    item[X_LSB + 32 +: FIELD_W] = x2;
    item[X_LSB + 48 +: FIELD_W] = x3;
    item[X_LSB + 64 +: FIELD_W] = x4;
    return item;
  endfunction

  function automatic lsh_result_t simhash_of(input logic [IN_W-1:0] item);
    lsh_result_t               r;
    longint                    acc;
    logic signed [FIELD_W-1:0] xv;
    r.signature = '0;
    for (int p = 0; p < NUM_PLANES_DEF; p++) begin
      acc = 0;
      for (int d = 0; d < VECTOR_DIM_DEF; d++) begin
        xv  = item[X_LSB + FIELD_W * d +: FIELD_W];
        acc += longint'(xv) * longint'(plane_coef[p * VECTOR_DIM_DEF + d]);
      end
      if (acc >= 0) r.signature[p] = 1'b1;
    end
    r.distance = DIST_W'($countones(r.signature ^ ref_signature));
    return r;
  endfunction

  task automatic track_accepted(input logic [IN_W-1:0] item);
    logic [1:0]  cmd;
    logic [3:0]  plane;
    logic [2:0]  dim;
    lsh_result_t r;
    cmd   = item[CMD_LSB +: 2];
    plane = item[PLANE_LSB +: 4];
    dim   = item[DIM_LSB +: 3];
    case (cmd)
      CMD_LOAD: begin
        if (plane < NUM_PLANES_DEF && dim < VECTOR_DIM_DEF)
          plane_coef[plane * VECTOR_DIM_DEF + dim] = item[COEF_LSB +: FIELD_W];
      end
      CMD_HASH, CMD_HASH_STORE: begin
        r = simhash_of(item);
        expected_signatures.push_back(r);
        if (cmd == CMD_HASH_STORE) ref_signature = r.signature;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [IN_W-1:0] item);
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_accepted(item);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_signatures.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_hash(input logic [1:0] cmd, input logic [15:0] x0,
      input logic [15:0] x1, input logic [15:0] x2, input logic [15:0] x3,
      input logic [15:0] x4);
    send_item(pack_item(cmd, 4'($urandom), 3'($urandom), 16'($urandom),
                        x0, x1, x2, x3, x4));
  endtask

  task automatic send_load(input logic [3:0] plane, input logic [2:0] dim,
      input logic [15:0] coef);
    send_item(pack_item(CMD_LOAD, plane, dim, coef, 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  // full table first, so that no hash ever reads an unwritten coefficient
  task automatic test_table_load();
    logic [15:0] coef;
    for (int p = 0; p < NUM_PLANES_DEF; p++) begin
      for (int d = 0; d < VECTOR_DIM_DEF; d++) begin
        case (p)
          0:       coef = 16'h7fff;
          1:       coef = 16'h8000;
          2:       coef = 16'h0000;
          3:       coef = (d % 2) ? 16'hf000 : 16'h1000;
          4:       coef = (d == 0) ? 16'h0001 : 16'h0000;
          default: coef = rand_sample();
        endcase
        send_load(4'(p), 3'(d), coef);
      end
    end
  endtask

  task automatic test_edge_vectors();
    send_hash(CMD_HASH, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_hash(CMD_HASH, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_hash(CMD_HASH, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    // sum exactly zero, then just below zero
    send_hash(CMD_HASH, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_hash(CMD_HASH, 16'h0001, 16'h0002, 16'h0000, 16'h0000, 16'h0000);
    send_hash(CMD_HASH, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
  endtask

  task automatic test_reference_update();
    send_hash(CMD_HASH_STORE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_hash(CMD_HASH, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_hash(CMD_HASH, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_hash(CMD_HASH_STORE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_hash(CMD_HASH, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
  endtask

  // unused command and out of range loads must leave the table alone
  task automatic test_ignored_items();
    send_hash(CMD_UNUSED, 16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001);
    send_load(4'd10, 3'd0, 16'h8000);
    send_load(4'd15, 3'd7, 16'h8000);
    send_load(4'd0, 3'd5, 16'h8000);
    send_load(4'd9, 3'd7, 16'h8000);
    send_hash(CMD_HASH, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    wait_results_drained();
    send_load(4'd2, 3'd0, 16'h8000);
    send_hash(CMD_HASH, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
  endtask

  task automatic test_random_stream(input int unsigned send_pct,
      input int unsigned recv_pct, input int n_items);
    int          sent;
    int unsigned pick;
    logic [15:0] xs [5];
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        send_load(4'($urandom_range(NUM_PLANES_DEF - 1)),
                  3'($urandom_range(VECTOR_DIM_DEF - 1)), rand_sample());
        sent++;
      end else if (pick < 25) begin
        send_load(4'($urandom_range(15)), 3'($urandom_range(7)), rand_sample());
        sent++;
      end else if (pick < 29) begin
        send_hash(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
        sent++;
      end else begin
        for (int d = 0; d < 5; d++)
          xs[d] = ($urandom_range(19) == 0) ? 16'h0000 : rand_sample();
        send_hash($urandom_range(1) ? CMD_HASH_STORE : CMD_HASH,
                  xs[0], xs[1], xs[2], xs[3], xs[4]);
        sent++;
      end
    end
    wait_results_drained();
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.signature = m_tdata[SIG_LSB +: SIG_OUT_W];
      got.distance  = m_tdata[DIST_LSB +: DIST_W];
      if (expected_signatures.size() == 0) begin
        $error("unexpected result: signature %h distance %0d",
               got.signature, got.distance);
        error_count++;
      end else begin
        want = expected_signatures.pop_front();
        if (got.signature !== want.signature) begin
          $error("signature: expected %h actual %h", want.signature, got.signature);
          error_count++;
        end
        if (got.distance !== want.distance) begin
          $error("distance_to_reference: expected %0d actual %0d",
                 want.distance, got.distance);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    ref_signature = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_table_load();
    test_edge_vectors();
    test_reference_update();
    test_ignored_items();
    wait_results_drained();
    test_random_stream(0, 0, 325);
    test_random_stream(66, 0, 325);
    test_random_stream(0, 66, 325);
    test_random_stream(31, 31, 325);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_signatures.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== random_hyperplane_lsh_signature_core.f =====
+incdir+rtl
rtl/rhlsh_pkg.sv
rtl/random_hyperplane_lsh_signature_core.sv
rtl/rhlsh_chk.sv
test/tb_top.sv
